/* hdl/bvac_pkg.sv */
// ----------------------------------------------------------------------------
// bvac_pkg
// Shared types, codes and sizes for the vendor advertisement classifier.
// ----------------------------------------------------------------------------
package bvac_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    // item kinds
    localparam logic [1:0] K_FEED   = 2'd0;
    localparam logic [1:0] K_READ   = 2'd1;
    localparam logic [1:0] K_CLEAR  = 2'd2;
    localparam logic [1:0] K_UNUSED = 2'd3;

    // result status
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // company identifiers
    localparam logic [15:0] CO_TRK_A = 16'h00D7;
    localparam logic [15:0] CO_TRK_B = 16'h00D8;
    localparam logic [15:0] CO_CONT  = 16'h004C;
    localparam logic [15:0] CO_TAG   = 16'h0075;
    localparam logic [15:0] CO_PAIR_A = 16'h0006;
    localparam logic [15:0] CO_PAIR_B = 16'h00F2;

    localparam logic [7:0] BATT_MASK   = 8'h7F;
    localparam logic [7:0] TB_FIND_NEAR = 8'h0F;
    localparam logic [7:0] TB_FIND_OFF  = 8'h10;

    // device type codes
    localparam logic [4:0] TC_NONE       = 5'd0;
    localparam logic [4:0] TC_TRK        = 5'd1;
    localparam logic [4:0] TC_TRK_NET    = 5'd2;
    localparam logic [4:0] TC_TAG        = 5'd3;
    localparam logic [4:0] TC_TAG_PLUS   = 5'd4;
    localparam logic [4:0] TC_TAG_FAMILY = 5'd5;
    localparam logic [4:0] TC_EARBUDS    = 5'd6;
    localparam logic [4:0] TC_TAG_UNK    = 5'd7;
    localparam logic [4:0] TC_FIND_NEAR  = 5'd8;
    localparam logic [4:0] TC_FIND_OFF   = 5'd9;
    localparam logic [4:0] TC_FILE_SHARE = 5'd10;
    localparam logic [4:0] TC_EAR        = 5'd11;
    localparam logic [4:0] TC_EAR_PRO    = 5'd12;
    localparam logic [4:0] TC_HEAD_MAX   = 5'd13;
    localparam logic [4:0] TC_SPEAKER    = 5'd14;
    localparam logic [4:0] TC_WATCH      = 5'd15;
    localparam logic [4:0] TC_TV_BOX     = 5'd16;
    localparam logic [4:0] TC_HANDOFF    = 5'd17;
    localparam logic [4:0] TC_TETHER     = 5'd18;
    localparam logic [4:0] TC_NEARBY     = 5'd19;
    localparam logic [4:0] TC_CONT_UNK   = 5'd20;
    localparam logic [4:0] TC_PAIR       = 5'd21;
    localparam logic [4:0] TC_PAIR_SETUP = 5'd22;
    localparam logic [4:0] TC_PAIR_BATT  = 5'd23;
    localparam logic [4:0] TC_PAIR_INFO  = 5'd24;
    localparam logic [4:0] TC_PAIR_UNK   = 5'd25;

    // per-slot record
    typedef struct packed {
        logic       present;
        logic [4:0] type_code;
        logic [7:0] type_byte;
        logic [6:0] trk_batt;
        logic       trk_seen;
        logic [7:0] tag_proto;
        logic [7:0] find_batt;
        logic [7:0] pair_batt;
        logic       pair_seen;
        logic       cont_vendor;
    } t_rec;

    // one result word
    typedef struct packed {
        logic [5:0] present_count;
        logic [4:0] vendor_flags;
        logic [7:0] batt_value;
        logic       batt_known;
        logic [7:0] type_byte;
        logic [4:0] type_code;
        logic       present;
        logic [4:0] entry_slot;
        logic [1:0] status;
    } t_res;

endpackage

/* hdl/ble_vendor_advert_classifier.sv */
// ----------------------------------------------------------------------------
// ble_vendor_advert_classifier
// Device table with address search and manufacturer-data classification.
// ----------------------------------------------------------------------------
// A feed searches the used slots, then reads the matched record or allocates a
// fresh slot, classifies and writes it back; a full table gives status full. A
// read fetches its record; clear, ignored feed and unused kind go straight to
// the result. The result word is registered as the block returns to idle; one
// item at a time, and a stalled output holds it. Reset (synchronous, active low)
// empties the table; records are zeroed on allocation, so no clearing pass.
module ble_vendor_advert_classifier (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // device_address[47:0], data_length[55:48], data_head[119:56],
    // data_byte_eight[127:120], slot[132:128], zero fill
    input  logic [135:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], entry_slot[6:2], present[7], type_code[12:8],
    // type_byte[20:13], batt_known[21], batt_value[29:22],
    // vendor_flags[34:30], present_count[40:35], zero fill
    output logic [47:0]  m_axis_tdata
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_REC    = 5'b00100,
        S_MOD    = 5'b01000,
        S_FIN    = 5'b10000
    } t_state;

    t_state r_state;

    logic [47:0]                 r_addr;
    logic [7:0]                  r_len;
    logic [63:0]                 r_head;
    logic [7:0]                  r_b8;
    logic [1:0]                  r_kind;
    logic [bvac_pkg::IDX_W-1:0]  r_idx;
    logic [bvac_pkg::IDX_W-1:0]  r_cmp_idx;
    logic                        r_cmp_vld;
    logic [bvac_pkg::CNT_W-1:0]  r_iss;
    logic [bvac_pkg::CNT_W-1:0]  r_used;
    logic [bvac_pkg::CNT_W-1:0]  r_total;
    logic                        r_new;
    bvac_pkg::t_res              r_res;
    bvac_pkg::t_res              r_out;
    logic                        r_out_vld;

    // memories
    logic [47:0]    r_amem [bvac_pkg::TABLE_ENTRIES];
    bvac_pkg::t_rec r_rmem [bvac_pkg::TABLE_ENTRIES];
    logic [47:0]    r_adq;
    bvac_pkg::t_rec r_rec_q;

    logic           a_we;
    logic           rec_we;
    bvac_pkg::t_rec n_rec;
    logic           n_inc;
    bvac_pkg::t_res n_rep;
    bvac_pkg::t_res n_start;
    t_state         n_start_st;
    logic           found;
    logic [7:0]     in_slot;

    function automatic logic [bvac_pkg::CNT_W-1:0] CNT_INC(input logic b);
        CNT_INC = {{(bvac_pkg::CNT_W-1){1'b0}}, b};
    endfunction

    assign in_slot       = {3'b0, s_axis_tdata[132:128]};
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'b0, r_out};
    assign found         = r_cmp_vld && (r_adq == r_addr);

    // address memory: one read per cycle at the search pointer
    always_ff @(posedge i_clk) begin
        if (a_we) begin
            r_amem[r_used[bvac_pkg::IDX_W-1:0]] <= r_addr;
        end
        r_adq <= r_amem[r_iss[bvac_pkg::IDX_W-1:0]];
    end

    // record memory: read at the current slot, write back after classify
    always_ff @(posedge i_clk) begin
        if (rec_we) begin
            r_rmem[r_idx] <= n_rec;
        end
        r_rec_q <= r_rmem[r_idx];
    end

    // allocate when the search ends without a match and a slot is free
    always_comb begin
        a_we = (r_state == S_SEARCH) && !found && !(r_iss < r_used)
               && (r_used < bvac_pkg::CNT_W'(bvac_pkg::TABLE_ENTRIES));
        rec_we = (r_state == S_MOD) && (r_kind == bvac_pkg::K_FEED);
    end

    // decode an incoming word into its first result and next state
    always_comb begin
        n_start               = '0;
        n_start.present_count = 6'(r_total);
        n_start_st            = S_FIN;
        unique case (s_axis_tuser)
            bvac_pkg::K_FEED: begin
                if (s_axis_tdata[55:48] == 8'd0) begin
                    n_start.status = bvac_pkg::ST_ZERO;
                end else begin
                    n_start_st = S_SEARCH;
                end
            end
            bvac_pkg::K_READ: begin
                n_start.entry_slot = s_axis_tdata[132:128];
                if (9'(in_slot) < 9'(r_used)
                    && 9'(in_slot) < 9'(bvac_pkg::TABLE_ENTRIES)) begin
                    n_start_st = S_REC;
                end
            end
            bvac_pkg::K_CLEAR: begin
                n_start.present_count = 6'd0;
            end
            default: ;
        endcase
    end

    // classify the fed bytes into the record
    always_comb begin
        bvac_pkg::t_rec e;
        logic [15:0]    co;
        logic [7:0]     t;
        logic [7:0]     d5, d6;
        logic [7:0]     lvl;
        e  = r_new ? '0 : r_rec_q;
        co = r_head[15:0];
        t  = r_head[39:32];
        d5 = r_head[47:40];
        d6 = r_head[55:48];
        if (r_kind == bvac_pkg::K_FEED && r_len >= 8'd6) begin
            if ((co == bvac_pkg::CO_TRK_A || co == bvac_pkg::CO_TRK_B) && r_len >= 8'd8) begin
                e.type_code = bvac_pkg::TC_TRK;
                e.type_byte = 8'd0;
                e.present   = 1'b1;
            end
            if (co == bvac_pkg::CO_CONT && r_len >= 8'd10 && t == bvac_pkg::TB_FIND_OFF) begin
                e.type_code = bvac_pkg::TC_TRK_NET;
                e.type_byte = 8'd0;
                e.trk_batt  = r_b8[6:0] & bvac_pkg::BATT_MASK[6:0];
                e.trk_seen  = 1'b1;
                e.present   = 1'b1;
            end
            if (!e.present && r_len >= 8'd8 && co == bvac_pkg::CO_TAG) begin
                e.type_byte = 8'd0;
                case (t)
                    8'h01:   e.type_code = bvac_pkg::TC_TAG;
                    8'h02:   e.type_code = bvac_pkg::TC_TAG_PLUS;
                    8'h03:   e.type_code = bvac_pkg::TC_TAG_FAMILY;
                    8'h05:   e.type_code = bvac_pkg::TC_EARBUDS;
                    default: begin
                        e.type_code = bvac_pkg::TC_TAG_UNK;
                        e.type_byte = t;
                    end
                endcase
                e.tag_proto = t;
                e.present   = 1'b1;
            end
            if (!e.present && r_len >= 8'd10 && co == bvac_pkg::CO_CONT
                && (t == bvac_pkg::TB_FIND_NEAR || t == bvac_pkg::TB_FIND_OFF)) begin
                e.find_batt = d6;
                e.type_code = (t == bvac_pkg::TB_FIND_NEAR) ? bvac_pkg::TC_FIND_NEAR
                                                            : bvac_pkg::TC_FIND_OFF;
                e.type_byte = 8'd0;
                e.present   = 1'b1;
            end
            if (!e.present && co == bvac_pkg::CO_CONT) begin
                e.type_byte = 8'd0;
                case (t)
                    8'h05:   e.type_code = bvac_pkg::TC_FILE_SHARE;
                    8'h07:   e.type_code = bvac_pkg::TC_EAR;
                    8'h09:   e.type_code = bvac_pkg::TC_EAR_PRO;
                    8'h0A:   e.type_code = bvac_pkg::TC_HEAD_MAX;
                    8'h0B:   e.type_code = bvac_pkg::TC_SPEAKER;
                    8'h0C:   e.type_code = bvac_pkg::TC_WATCH;
                    8'h0E:   e.type_code = bvac_pkg::TC_TV_BOX;
                    8'h12:   e.type_code = bvac_pkg::TC_HANDOFF;
                    8'h13:   e.type_code = bvac_pkg::TC_TETHER;
                    8'h15:   e.type_code = bvac_pkg::TC_NEARBY;
                    default: begin
                        e.type_code = bvac_pkg::TC_CONT_UNK;
                        e.type_byte = t;
                    end
                endcase
                e.cont_vendor = 1'b1;
                e.present     = 1'b1;
            end
            if (!e.present && (co == bvac_pkg::CO_PAIR_A || co == bvac_pkg::CO_PAIR_B)) begin
                e.type_byte = 8'd0;
                case (t)
                    8'h00:   e.type_code = bvac_pkg::TC_PAIR;
                    8'h01:   e.type_code = bvac_pkg::TC_PAIR_SETUP;
                    8'h02:   begin
                        e.type_code = bvac_pkg::TC_PAIR_BATT;
                        if (r_len >= 8'd7) begin
                            e.pair_batt = d5;
                            e.pair_seen = 1'b1;
                        end
                    end
                    8'h03:   e.type_code = bvac_pkg::TC_PAIR_INFO;
                    default: begin
                        e.type_code = bvac_pkg::TC_PAIR_UNK;
                        e.type_byte = t;
                    end
                endcase
                e.present = 1'b1;
            end
        end
        n_rec = e;
        n_inc = e.present && !(r_new ? 1'b0 : r_rec_q.present) && (r_kind == bvac_pkg::K_FEED);

        // report the record
        lvl = (e.trk_batt != 7'd0) ? {1'b0, e.trk_batt} : e.pair_batt;
        if (lvl == 8'd0 && e.find_batt != 8'd0) begin
            lvl = e.find_batt;
        end
        n_rep               = '0;
        n_rep.status        = bvac_pkg::ST_DONE;
        n_rep.entry_slot    = 5'(r_idx);
        n_rep.present       = e.present;
        n_rep.type_code     = e.type_code;
        n_rep.type_byte     = e.type_byte;
        n_rep.batt_known    = e.trk_seen || e.pair_seen || (e.find_batt != 8'd0);
        n_rep.batt_value    = lvl;
        n_rep.vendor_flags[0] = e.cont_vendor;
        n_rep.vendor_flags[1] = (e.tag_proto != 8'd0);
        n_rep.vendor_flags[2] = (e.type_code == bvac_pkg::TC_TRK)
                                || (e.type_code == bvac_pkg::TC_TRK_NET);
        n_rep.vendor_flags[3] = (e.type_code == bvac_pkg::TC_FIND_NEAR)
                                || (e.type_code == bvac_pkg::TC_FIND_OFF);
        n_rep.vendor_flags[4] = (e.type_code >= bvac_pkg::TC_PAIR)
                                && (e.type_code <= bvac_pkg::TC_PAIR_UNK);
        n_rep.present_count = 6'(r_total + CNT_INC(n_inc));
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_total   <= '0;
            r_out_vld <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_iss     <= '0;
        end else begin
            // load the output register, or drain it
            if (r_state == S_FIN && (!r_out_vld || m_axis_tready)) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_addr    <= s_axis_tdata[47:0];
                        r_len     <= s_axis_tdata[55:48];
                        r_head    <= s_axis_tdata[119:56];
                        r_b8      <= s_axis_tdata[127:120];
                        r_kind    <= s_axis_tuser;
                        r_iss     <= '0;
                        r_cmp_vld <= 1'b0;
                        r_res     <= n_start;
                        r_state   <= n_start_st;
                        if (s_axis_tuser == bvac_pkg::K_READ) begin
                            r_idx <= s_axis_tdata[128 +: bvac_pkg::IDX_W];
                            r_new <= 1'b0;
                        end
                        if (s_axis_tuser == bvac_pkg::K_CLEAR) begin
                            r_used  <= '0;
                            r_total <= '0;
                        end
                    end
                end
                S_SEARCH: begin
                    if (found) begin
                        r_idx   <= r_cmp_idx;
                        r_new   <= 1'b0;
                        r_state <= S_REC;
                    end else if (r_iss < r_used) begin
                        r_cmp_idx <= r_iss[bvac_pkg::IDX_W-1:0];
                        r_cmp_vld <= 1'b1;
                        r_iss     <= r_iss + 1'b1;
                    end else if (a_we) begin
                        r_idx   <= r_used[bvac_pkg::IDX_W-1:0];
                        r_used  <= r_used + 1'b1;
                        r_new   <= 1'b1;
                        r_state <= S_MOD;
                    end else begin
                        r_res.status <= bvac_pkg::ST_FULL;
                        r_state      <= S_FIN;
                    end
                end
                S_REC: begin
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    if (n_inc) begin
                        r_total <= r_total + 1'b1;
                    end
                    r_res   <= n_rep;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (!r_out_vld || m_axis_tready) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

/* dv/tb_ble_vendor_advert_classifier.sv */
// ----------------------------------------------------------------------------
// tb_ble_vendor_advert_classifier
// Self-checking bench for the vendor advertisement classifier: drives feed,
// read, clear and unused-kind words, predicts every result word with a
// table and classifier model, and compares results field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Device table model and store of expected result words
class advert_table_sb;
    logic [47:0]    addr_tab[bvac_pkg::TABLE_ENTRIES];
    bvac_pkg::t_rec recs[bvac_pkg::TABLE_ENTRIES];
    int             used;
    int             total;
    bvac_pkg::t_res pending[$];
    int             errors;

    function new();
        used   = 0;
        total  = 0;
        errors = 0;
        foreach (recs[i]) recs[i] = '0;
    endfunction

    function void mark(ref bvac_pkg::t_rec e);
        if (!e.present) begin
            e.present = 1'b1;
            total++;
        end
    endfunction

    function void set_tc(ref bvac_pkg::t_rec e, input logic [4:0] tc, input logic [7:0] tb);
        e.type_code = tc;
        e.type_byte = tb;
    endfunction

    // Run the decoder chain on one record
    function void classify(ref bvac_pkg::t_rec e, input logic [7:0] d[9], input int len);
        logic [15:0] co;
        logic [7:0]  t;
        if (len < 6) return;
        co = {d[1], d[0]};
        t  = d[4];
        if ((co == bvac_pkg::CO_TRK_A || co == bvac_pkg::CO_TRK_B) && len >= 8) begin
            set_tc(e, bvac_pkg::TC_TRK, 8'd0);
            mark(e);
        end
        if (co == bvac_pkg::CO_CONT && len >= 10 && t == bvac_pkg::TB_FIND_OFF) begin
            set_tc(e, bvac_pkg::TC_TRK_NET, 8'd0);
            e.trk_batt = d[8][6:0];
            e.trk_seen = 1'b1;
            mark(e);
        end
        if (!e.present && len >= 8 && co == bvac_pkg::CO_TAG) begin
            case (t)
                8'h01:   set_tc(e, bvac_pkg::TC_TAG, 8'd0);
                8'h02:   set_tc(e, bvac_pkg::TC_TAG_PLUS, 8'd0);
                8'h03:   set_tc(e, bvac_pkg::TC_TAG_FAMILY, 8'd0);
                8'h05:   set_tc(e, bvac_pkg::TC_EARBUDS, 8'd0);
                default: set_tc(e, bvac_pkg::TC_TAG_UNK, t);
            endcase
            e.tag_proto = t;
            mark(e);
        end
        if (!e.present && len >= 10 && co == bvac_pkg::CO_CONT &&
            (t == bvac_pkg::TB_FIND_NEAR || t == bvac_pkg::TB_FIND_OFF)) begin
            e.find_batt = d[6];
            set_tc(e, (t == bvac_pkg::TB_FIND_NEAR) ? bvac_pkg::TC_FIND_NEAR
                                                    : bvac_pkg::TC_FIND_OFF, 8'd0);
            mark(e);
        end
        if (!e.present && co == bvac_pkg::CO_CONT) begin
            case (t)
                8'h05:   set_tc(e, bvac_pkg::TC_FILE_SHARE, 8'd0);
                8'h07:   set_tc(e, bvac_pkg::TC_EAR, 8'd0);
                8'h09:   set_tc(e, bvac_pkg::TC_EAR_PRO, 8'd0);
                8'h0A:   set_tc(e, bvac_pkg::TC_HEAD_MAX, 8'd0);
                8'h0B:   set_tc(e, bvac_pkg::TC_SPEAKER, 8'd0);
                8'h0C:   set_tc(e, bvac_pkg::TC_WATCH, 8'd0);
                8'h0E:   set_tc(e, bvac_pkg::TC_TV_BOX, 8'd0);
                8'h12:   set_tc(e, bvac_pkg::TC_HANDOFF, 8'd0);
                8'h13:   set_tc(e, bvac_pkg::TC_TETHER, 8'd0);
                8'h15:   set_tc(e, bvac_pkg::TC_NEARBY, 8'd0);
                default: set_tc(e, bvac_pkg::TC_CONT_UNK, t);
            endcase
            e.cont_vendor = 1'b1;
            mark(e);
        end
        if (!e.present && (co == bvac_pkg::CO_PAIR_A || co == bvac_pkg::CO_PAIR_B)) begin
            case (t)
                8'h00: set_tc(e, bvac_pkg::TC_PAIR, 8'd0);
                8'h01: set_tc(e, bvac_pkg::TC_PAIR_SETUP, 8'd0);
                8'h02: begin
                    set_tc(e, bvac_pkg::TC_PAIR_BATT, 8'd0);
                    if (len >= 7) begin
                        e.pair_batt = d[5];
                        e.pair_seen = 1'b1;
                    end
                end
                8'h03:   set_tc(e, bvac_pkg::TC_PAIR_INFO, 8'd0);
                default: set_tc(e, bvac_pkg::TC_PAIR_UNK, t);
            endcase
            mark(e);
        end
    endfunction

    function void fill_fields(ref bvac_pkg::t_res r, input bvac_pkg::t_rec e);
        logic [7:0] lvl;
        r.present    = e.present;
        r.type_code  = e.type_code;
        r.type_byte  = e.type_byte;
        r.batt_known = e.trk_seen || e.pair_seen || (e.find_batt != 0);
        lvl = (e.trk_batt != 0) ? {1'b0, e.trk_batt} : e.pair_batt;
        if (lvl == 0 && e.find_batt != 0) lvl = e.find_batt;
        r.batt_value   = lvl;
        r.vendor_flags = {e.type_code >= bvac_pkg::TC_PAIR && e.type_code <= bvac_pkg::TC_PAIR_UNK,
                          e.type_code == bvac_pkg::TC_FIND_NEAR
                              || e.type_code == bvac_pkg::TC_FIND_OFF,
                          e.type_code == bvac_pkg::TC_TRK || e.type_code == bvac_pkg::TC_TRK_NET,
                          e.tag_proto != 0, e.cont_vendor};
    endfunction

    // Note one accepted input word and queue its expected result
    function void note_item(logic [1:0] kind, logic [135:0] w);
        bvac_pkg::t_res r;
        logic [47:0]    a;
        int             len, idx;
        bit             found;
        logic [7:0]     d[9];
        r = '0;
        a = w[47:0];
        len = int'(w[55:48]);
        if (kind == bvac_pkg::K_FEED) begin
            if (len == 0) begin
                r.status = bvac_pkg::ST_ZERO;
            end else begin
                found = 0;
                idx = 0;
                for (int i = 0; i < used; i++) begin
                    if (!found && addr_tab[i] == a) begin
                        idx = i;
                        found = 1;
                    end
                end
                if (!found && used < bvac_pkg::TABLE_ENTRIES) begin
                    idx = used++;
                    addr_tab[idx] = a;
                    recs[idx] = '0;
                    found = 1;
                end
                if (!found) begin
                    r.status = bvac_pkg::ST_FULL;
                end else begin
                    for (int i = 0; i < 8; i++) d[i] = w[56 + 8*i +: 8];
                    d[8] = w[127:120];
                    classify(recs[idx], d, len);
                    r.entry_slot = 5'(idx);
                    fill_fields(r, recs[idx]);
                end
            end
        end else if (kind == bvac_pkg::K_READ) begin
            r.entry_slot = w[132:128];
            if (w[132:128] < used) fill_fields(r, recs[w[132:128]]);
        end else if (kind == bvac_pkg::K_CLEAR) begin
            used  = 0;
            total = 0;
            foreach (recs[i]) recs[i] = '0;
        end
        r.present_count = 6'(total);
        pending.push_back(r);
    endfunction

    function void flag(string fld, int e, int g);
        errors++;
        if (errors <= 10)
            $display("mismatch %s: expected %0d, got %0d", fld, e, g);
    endfunction

    // Compare one result word with the oldest expectation
    function void check_word(logic [47:0] w);
        bvac_pkg::t_res g, e;
        g = w[40:0];
        if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %h", w);
            return;
        end
        e = pending.pop_front();
        if (g.status !== e.status) flag("status", e.status, g.status);
        if (g.entry_slot !== e.entry_slot) flag("entry_slot", e.entry_slot, g.entry_slot);
        if (g.present !== e.present) flag("present", e.present, g.present);
        if (g.type_code !== e.type_code) flag("type_code", e.type_code, g.type_code);
        if (g.type_byte !== e.type_byte) flag("type_byte", e.type_byte, g.type_byte);
        if (g.batt_known !== e.batt_known)
            flag("batt_known", e.batt_known, g.batt_known);
        if (g.batt_value !== e.batt_value)
            flag("batt_value", e.batt_value, g.batt_value);
        if (g.vendor_flags !== e.vendor_flags)
            flag("vendor_flags", e.vendor_flags, g.vendor_flags);
        if (g.present_count !== e.present_count)
            flag("present_count", e.present_count, g.present_count);
    endfunction
endclass

module tb_ble_vendor_advert_classifier;

    localparam int CYCLE_LIMIT = 1000000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // device_address, data_length, data_head, data_byte_eight, slot, zero fill
    logic [135:0] s_axis_tdata = '0;
    // kind
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // status, entry_slot, present, type_code, type_byte, batt_known,
    // batt_value, vendor_flags, present_count, zero fill
    logic [47:0]  m_axis_tdata;

    advert_table_sb sb = new();
    bit          calm = 0;
    bit          hold_off = 0;
    int          cycles = 0;
    logic [47:0] addr_pool[40];

    ble_vendor_advert_classifier i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stall the result side at random, or hold off entirely
    always @(negedge i_clk) begin
        if (hold_off) m_axis_tready <= 1'b0;
        else m_axis_tready <= calm || ($urandom_range(99) >= 15);
    end

    // Check each accepted result word
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata);
    end

    // Long receiver hold-off while the sender keeps offering words
    initial begin
        wait (i_rst_n);
        repeat (3000) @(posedge i_clk);
        hold_off = 1;
        repeat (600) @(posedge i_clk);
        hold_off = 0;
    end

    // Offer one word and hold it until accepted
    task send_word(logic [1:0] kind, logic [135:0] w);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 15) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= w;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_item(kind, w);
    endtask

    task feed(logic [47:0] a, logic [7:0] len, logic [15:0] co, logic [7:0] t);
        logic [63:0] head;
        head = {$urandom, $urandom};
        head[15:0]  = co;
        head[39:32] = t;
        send_word(bvac_pkg::K_FEED, {3'b0, 5'($urandom), 8'($urandom), head, len, a});
    endtask

    task read_slot(logic [4:0] s);
        send_word(bvac_pkg::K_READ,
                  {3'b0, s, 128'({$urandom, $urandom, $urandom, $urandom})});
    endtask

    // Pick a company id, mostly a known one
    function logic [15:0] pick_co();
        case ($urandom_range(7))
            0: return bvac_pkg::CO_TRK_A;
            1: return bvac_pkg::CO_TRK_B;
            2, 3: return bvac_pkg::CO_CONT;
            4: return bvac_pkg::CO_TAG;
            5: return bvac_pkg::CO_PAIR_A;
            6: return bvac_pkg::CO_PAIR_B;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int k;
        foreach (addr_pool[i]) addr_pool[i] = {16'($urandom), $urandom};
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, every kind and the decoder corner cases
        feed(48'h0, 8'd0, bvac_pkg::CO_CONT, 8'h10);
        feed(48'h0, 8'd8, bvac_pkg::CO_TRK_A, 8'h00);
        feed(48'hFFFF_FFFF_FFFF, 8'd7, bvac_pkg::CO_TRK_B, 8'h00);
        feed(48'hFFFF_FFFF_FFFF, 8'd255, bvac_pkg::CO_TRK_B, 8'h00);
        feed(48'h1, 8'd10, bvac_pkg::CO_CONT, bvac_pkg::TB_FIND_OFF);
        feed(48'h2, 8'd10, bvac_pkg::CO_CONT, bvac_pkg::TB_FIND_NEAR);
        feed(48'h3, 8'd9, bvac_pkg::CO_CONT, bvac_pkg::TB_FIND_OFF);
        feed(48'h4, 8'd6, bvac_pkg::CO_CONT, 8'h07);
        feed(48'h5, 8'd8, bvac_pkg::CO_TAG, 8'h01);
        feed(48'h6, 8'd8, bvac_pkg::CO_TAG, 8'h05);
        feed(48'h7, 8'd8, bvac_pkg::CO_TAG, 8'h00);
        feed(48'h8, 8'd7, bvac_pkg::CO_PAIR_A, 8'h02);
        feed(48'h9, 8'd6, bvac_pkg::CO_PAIR_B, 8'h02);
        feed(48'hA, 8'd6, bvac_pkg::CO_PAIR_B, 8'hFF);
        feed(48'hB, 8'd5, bvac_pkg::CO_CONT, 8'h05);
        feed(48'h2, 8'd10, bvac_pkg::CO_CONT, bvac_pkg::TB_FIND_OFF);
        send_word(bvac_pkg::K_UNUSED, '1);
        read_slot(5'd0);
        read_slot(5'd31);
        send_word(bvac_pkg::K_CLEAR, '0);
        read_slot(5'd0);

        // Random: mostly pooled addresses so the table fills and repeats
        for (int n = 0; n < 1600; n++) begin
            calm = (n >= 700 && n < 900);
            k = $urandom_range(99);
            if (k < 1) begin
                send_word(bvac_pkg::K_CLEAR,
                          {$urandom, $urandom, $urandom, $urandom, 8'($urandom)});
            end else if (k < 3) begin
                send_word(bvac_pkg::K_UNUSED,
                          {$urandom, $urandom, $urandom, $urandom, 8'($urandom)});
            end else if (k < 18) begin
                read_slot(5'($urandom));
            end else begin
                feed(($urandom_range(9) == 0) ? {16'($urandom), $urandom}
                                              : addr_pool[$urandom_range(39)],
                     ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(12)),
                     pick_co(),
                     ($urandom_range(2) == 0) ? 8'($urandom) : 8'($urandom_range(21)));
            end
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;

        // Drain, then let the pipeline settle
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
